[hdl/smsrch_pkg.sv]
// Shared types and constants for the sorted matrix search block.
// No dependencies; imported by the controller and the top level.
`default_nettype none

package smsrch_pkg;

    // Width of the row and column count registers.
    localparam int CNT_W = 5;

    // Width of one matrix entry.
    localparam int DATA_W = 32;

    // Width of the row and column index fields of a write item.
    localparam int IDX_W = 4;

    // Register indexes on the configuration port.
    localparam logic CFG_ROWS_IN_USE = 1'b0;
    localparam logic CFG_COLS_IN_USE = 1'b1;

    // Reset values of the count registers.
    localparam logic [CNT_W-1:0] ROWS_RESET = 5'd16;
    localparam logic [CNT_W-1:0] COLS_RESET = 5'd16;

    // Request codes carried by req_type.
    localparam logic REQ_WRITE  = 1'b0;
    localparam logic REQ_SEARCH = 1'b1;

    // Matrix extent currently in use, as written through the configuration port.
    typedef struct packed {
        logic [CNT_W-1:0] rows;
        logic [CNT_W-1:0] cols;
    } cfg_t;

endpackage

`default_nettype wire

[hdl/sorted_matrix_search_top.sv]
// Top level of the sorted matrix search block: configuration registers,
// matrix RAM and controller. Depends on smsrch_pkg, smsrch_ram, smsrch_ctrl.
`default_nettype none

// The block holds a matrix of signed 32-bit words in a RAM of MAX_ROWS by
// MAX_COLS entries and answers searches with a staircase walk that starts at
// row 0 and the last column in use. A write item gives no result. A search
// visits at most rows + cols - 1 entries; each step of the walk is one read
// of the single RAM read port, whose registered read sets the pace.
// Items are handled one at a time; a finished result waits in an output
// register so the next item can be taken meanwhile.
// Entries must be written before a search reads them. The configuration port
// is always ready and must only be written while no item is in flight.
module sorted_matrix_search_top
    import smsrch_pkg::*;
#(
    parameter int MAX_ROWS = 16,
    parameter int MAX_COLS = 16
)
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    // Request channel.
    input  wire logic                     in_valid,
    output logic                          in_stall,
    input  wire logic                     req_type,
    input  wire logic [IDX_W-1:0]         row_index,
    input  wire logic [IDX_W-1:0]         col_index,
    input  wire logic signed [DATA_W-1:0] entry_value,
    input  wire logic signed [DATA_W-1:0] search_key,
    // Result channel.
    output logic                          out_valid,
    input  wire logic                     out_stall,
    output logic                          found,
    // Configuration write channel.
    input  wire logic                     cfg_valid,
    output logic                          cfg_ready,
    input  wire logic                     cfg_index,
    input  wire logic [CNT_W-1:0]         cfg_data
);

    localparam int DEPTH = MAX_ROWS * MAX_COLS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    cfg_t              cfg_reg, cfg_next;
    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    logic [DATA_W-1:0] mem_wdata;
    logic              mem_re;
    logic [AW-1:0]     mem_raddr;
    logic [DATA_W-1:0] mem_rdata;

    assign cfg_ready = 1'b1;

    // Register decode for configuration transfers.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_ROWS_IN_USE: cfg_next.rows = cfg_data;
                CFG_COLS_IN_USE: cfg_next.cols = cfg_data;
                default:         cfg_next      = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.rows <= ROWS_RESET;
            cfg_reg.cols <= COLS_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Matrix storage.
    smsrch_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // Request handling and search walk.
    smsrch_ctrl #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .req_type    (req_type),
        .row_index   (row_index),
        .col_index   (col_index),
        .entry_value (entry_value),
        .search_key  (search_key),
        .mem_we      (mem_we),
        .mem_waddr   (mem_waddr),
        .mem_wdata   (mem_wdata),
        .mem_re      (mem_re),
        .mem_raddr   (mem_raddr),
        .mem_rdata   (mem_rdata),
        .res_valid   (out_valid),
        .res_stall   (out_stall),
        .res_found   (found)
    );

endmodule

`default_nettype wire

[hdl/smsrch_ram.sv]
// Generic single-clock RAM with one write port and one registered read port.
// No dependencies.
`default_nettype none

module smsrch_ram
#(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
)
(
    input  wire logic                                clk,
    input  wire logic                                we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                    wdata,
    input  wire logic                                re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                    rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

[hdl/smsrch_ctrl.sv]
// Request controller and staircase walker of the sorted matrix search block.
// Depends on smsrch_pkg; drives the matrix RAM (smsrch_ram) in the top level.
`default_nettype none

module smsrch_ctrl
    import smsrch_pkg::*;
#(
    parameter int MAX_ROWS = 16,
    parameter int MAX_COLS = 16,
    localparam int DEPTH   = MAX_ROWS * MAX_COLS,
    localparam int AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1
)
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire cfg_t                     cfg,
    // Request channel.
    input  wire logic                     in_valid,
    output logic                          in_stall,
    input  wire logic                     req_type,
    input  wire logic [IDX_W-1:0]         row_index,
    input  wire logic [IDX_W-1:0]         col_index,
    input  wire logic signed [DATA_W-1:0] entry_value,
    input  wire logic signed [DATA_W-1:0] search_key,
    // Matrix RAM.
    output logic                          mem_we,
    output logic [AW-1:0]                 mem_waddr,
    output logic [DATA_W-1:0]             mem_wdata,
    output logic                          mem_re,
    output logic [AW-1:0]                 mem_raddr,
    input  wire logic [DATA_W-1:0]        mem_rdata,
    // Result channel.
    output logic                          res_valid,
    input  wire logic                     res_stall,
    output logic                          res_found
);

    // Count limits, held to what a 5-bit count can express.
    localparam int CNT_MAX  = (1 << CNT_W) - 1;
    localparam int ROW_LIM  = (MAX_ROWS > CNT_MAX) ? CNT_MAX : MAX_ROWS;
    localparam int COL_LIM  = (MAX_COLS > CNT_MAX) ? CNT_MAX : MAX_COLS;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_WALK = 3'b010,
        ST_DONE = 3'b100
    } state_t;

    // Linear address of entry (r, c); rows are MAX_COLS words apart.
    function automatic logic [AW-1:0] addr_of(input logic [CNT_W-1:0] r,
                                              input logic [CNT_W-1:0] c);
        logic [31:0] wide;
        wide = 32'(r) * 32'(MAX_COLS) + 32'(c);
        return wide[AW-1:0];
    endfunction

    state_t                    state_reg,   state_next;
    logic [CNT_W-1:0]          row_reg,     row_next;
    logic [CNT_W-1:0]          left_reg,    left_next;
    logic [CNT_W-1:0]          rows_reg,    rows_next;
    logic signed [DATA_W-1:0]  key_reg,     key_next;
    logic                      hit_reg,     hit_next;
    logic                      out_valid_reg, out_valid_next;
    logic                      found_reg,   found_next;

    logic [CNT_W-1:0]          rows_eff;
    logic [CNT_W-1:0]          cols_eff;
    logic                      accept;
    logic                      wr_in_range;
    logic [31:0]               wr_addr_wide;
    logic                      entry_eq;
    logic                      entry_lt;
    logic [CNT_W-1:0]          row_inc;
    logic [CNT_W-1:0]          left_dec;
    logic                      slot_free;

    // Counts above the matrix size act as the matrix size.
    assign rows_eff = (cfg.rows > CNT_W'(ROW_LIM)) ? CNT_W'(ROW_LIM) : cfg.rows;
    assign cols_eff = (cfg.cols > CNT_W'(COL_LIM)) ? CNT_W'(COL_LIM) : cfg.cols;

    // One item at a time: new requests are taken only between searches.
    assign in_stall = (state_reg != ST_IDLE);
    assign accept   = in_valid && !in_stall;

    // Write path straight into the RAM; out-of-range writes are dropped.
    assign wr_in_range  = (32'(row_index) < 32'(MAX_ROWS)) &&
                          (32'(col_index) < 32'(MAX_COLS));
    assign wr_addr_wide = 32'(row_index) * 32'(MAX_COLS) + 32'(col_index);
    assign mem_we       = accept && (req_type == REQ_WRITE) && wr_in_range;
    assign mem_waddr    = wr_addr_wide[AW-1:0];
    assign mem_wdata    = entry_value;

    // Compare of the entry just read with the key.
    assign entry_eq = ($signed(mem_rdata) == key_reg);
    assign entry_lt = ($signed(mem_rdata) <  key_reg);
    assign row_inc  = row_reg + CNT_W'(1);
    assign left_dec = left_reg - CNT_W'(1);

    // The output register can take a new result this cycle.
    assign slot_free = !out_valid_reg || !res_stall;

    // Search sequencer: issue a read, compare the returned entry, step.
    always_comb
    begin
        state_next     = state_reg;
        row_next       = row_reg;
        left_next      = left_reg;
        rows_next      = rows_reg;
        key_next       = key_reg;
        hit_next       = hit_reg;
        out_valid_next = out_valid_reg;
        found_next     = found_reg;
        mem_re         = 1'b0;
        mem_raddr      = addr_of(row_reg, left_dec);

        // A transfer on the result channel empties the output register.
        if (out_valid_reg && !res_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && (req_type == REQ_SEARCH))
                begin
                    row_next  = '0;
                    left_next = cols_eff;
                    rows_next = rows_eff;
                    key_next  = search_key;
                    hit_next  = 1'b0;
                    if ((rows_eff == '0) || (cols_eff == '0))
                    begin
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        mem_re     = 1'b1;
                        mem_raddr  = addr_of('0, cols_eff - CNT_W'(1));
                        state_next = ST_WALK;
                    end
                end
            end

            ST_WALK:
            begin
                if (entry_eq)
                begin
                    hit_next   = 1'b1;
                    state_next = ST_DONE;
                end
                else if (entry_lt)
                begin
                    // Entry too small: move down one row.
                    row_next = row_inc;
                    if (row_inc >= rows_reg)
                    begin
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        mem_re    = 1'b1;
                        mem_raddr = addr_of(row_inc, left_dec);
                    end
                end
                else
                begin
                    // Entry too large: move left one column.
                    left_next = left_dec;
                    if (left_dec == '0)
                    begin
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        mem_re    = 1'b1;
                        mem_raddr = addr_of(row_reg, left_dec - CNT_W'(1));
                    end
                end
            end

            ST_DONE:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    found_next     = hit_reg;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Walk position, key and result payload.
    always_ff @(posedge clk)
    begin
        row_reg   <= row_next;
        left_reg  <= left_next;
        rows_reg  <= rows_next;
        key_reg   <= key_next;
        hit_reg   <= hit_next;
        found_reg <= found_next;
    end

    assign res_valid = out_valid_reg;
    assign res_found = found_reg;

endmodule

`default_nettype wire
